[src/pee_pkg.sv]
// Package for the postfix expression evaluator: character codes, widths
// and the default stack depth. No dependencies.
package pee_pkg;
  localparam int unsigned DataW      = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned StackDepth = 64;

  localparam logic [SymW-1:0] SymNul   = 8'h00;
  localparam logic [SymW-1:0] SymZero  = 8'h30;
  localparam logic [SymW-1:0] SymNine  = 8'h39;
  localparam logic [SymW-1:0] SymPlus  = 8'h2B;
  localparam logic [SymW-1:0] SymMinus = 8'h2D;
  localparam logic [SymW-1:0] SymMul   = 8'h2A;
  localparam logic [SymW-1:0] SymDiv   = 8'h2F;
  localparam logic [SymW-1:0] SymPow   = 8'h5E;

  localparam logic [DataW-1:0] EmptyVal = '1;

  // Operation code for the iterative arithmetic unit.
  localparam logic [1:0] OpMul = 2'd0;
  localparam logic [1:0] OpDiv = 2'd1;
  localparam logic [1:0] OpPow = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;
endpackage

[src/postfix_expression_evaluator.sv]
// Top level of the postfix expression evaluator: sequencer, operand stack
// RAM and iterative arithmetic unit. Uses pee_pkg, pee_ram and pee_alu.
//
// The block takes one ASCII character per input transaction and evaluates a
// reverse Polish expression on a signed 32-bit stack held in a synchronous
// RAM of STACK_DEPTH entries. Digits push their value; + - * / ^ pop two
// operands and push the result (a divide by zero pushes nothing); NUL emits
// the top of stack (or -1 when empty) with a sticky overflow flag and
// empties the stack. Other codes are ignored. One item is in work at a time.
// A digit is pushed as it is accepted. NUL reads the top of stack, then waits
// for the output register to drain; + and - read both operands from the RAM,
// then write the result; * / ^ read the operands, then start the shared
// arithmetic unit, which retires one bit per cycle over 32 steps. The
// output register lets the next item be accepted while a result still waits.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pee_pkg::StackDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sym
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [32] overflowed, rest zero
);
  localparam int unsigned W  = pee_pkg::DataW;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdB  = 3'd1;  // address op2, wait
  localparam logic [2:0] StRdA  = 3'd2;  // latch op2, address op1
  localparam logic [2:0] StOp   = 3'd3;  // latch op1, compute or go to alu
  localparam logic [2:0] StAlu  = 3'd4;
  localparam logic [2:0] StNul  = 3'd5;  // wait for top read
  localparam logic [2:0] StOut  = 3'd6;  // wait for output slot

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;      // live entries
  logic [CW-1:0]       pops_r, pops_nxt;    // entries still to pop
  logic                ovf_r, ovf_nxt;
  logic [7:0]          sym_r, sym_nxt;
  logic [W-1:0]        opb_r, opb_nxt, opa_r, opa_nxt;
  logic                bvalid_r, bvalid_nxt, avalid_r, avalid_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [W-1:0]        oval_r, oval_nxt;
  logic                oovf_r, oovf_nxt;
  logic                we;
  logic [AW-1:0]       addr;
  logic [W-1:0]        wdata, rdata;
  pee_pkg::alu_ctl_t   alu_ctl;
  logic                alu_done;
  logic [W-1:0]        alu_res;
  logic                push_en;
  logic [W-1:0]        push_val;
  logic                in_fire, out_fire, slot_free;
  logic [W-1:0]        b_eff, a_eff, pow_res;

  pee_ram #(.Width(W), .Depth(STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  pee_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .op_a(opa_r), .op_b(opb_r),
    .done(alu_done), .result(alu_res)
  );

  assign out_fire  = ovalid_r && out_tready;
  assign slot_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == StIdle);
  assign in_fire   = in_tvalid && in_tready;

  // Operands read from an empty stack appear as -1. op1 is taken straight
  // from the RAM output in the cycle it arrives.
  assign b_eff = bvalid_r ? opb_r : pee_pkg::EmptyVal;
  assign a_eff = avalid_r ? rdata : pee_pkg::EmptyVal;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pops_nxt   = pops_r;
    ovf_nxt    = ovf_r;
    sym_nxt    = sym_r;
    opb_nxt    = opb_r;
    opa_nxt    = opa_r;
    bvalid_nxt = bvalid_r;
    avalid_nxt = avalid_r;
    ovalid_nxt = out_fire ? 1'b0 : ovalid_r;
    oval_nxt   = oval_r;
    oovf_nxt   = oovf_r;
    addr       = AW'(cnt_r);
    we         = 1'b0;
    wdata      = '0;
    alu_ctl    = '{start: 1'b0, op: pee_pkg::OpMul};
    push_en    = 1'b0;
    push_val   = '0;
    pow_res    = '0;

    unique case (state_r)
      StIdle: begin
        if (in_fire) begin
          sym_nxt = in_tdata;
          if (in_tdata == pee_pkg::SymNul) begin
            addr      = AW'(cnt_r - CW'(1));
            state_nxt = StNul;
          end else if (in_tdata >= pee_pkg::SymZero && in_tdata <= pee_pkg::SymNine) begin
            push_en  = 1'b1;
            push_val = W'(in_tdata - pee_pkg::SymZero);
          end else if (in_tdata == pee_pkg::SymPlus || in_tdata == pee_pkg::SymMinus
                    || in_tdata == pee_pkg::SymMul || in_tdata == pee_pkg::SymDiv
                    || in_tdata == pee_pkg::SymPow) begin
            addr       = AW'(cnt_r - CW'(1));
            bvalid_nxt = (cnt_r != '0);
            avalid_nxt = (cnt_r > CW'(1));
            pops_nxt   = (cnt_r > CW'(1)) ? CW'(2) : cnt_r;
            state_nxt  = StRdB;
          end
        end
      end
      StRdB: begin
        addr      = AW'(cnt_r - CW'(1));
        state_nxt = StRdA;
      end
      StRdA: begin
        addr      = AW'(cnt_r - CW'(2));
        opb_nxt   = rdata;
        state_nxt = StOp;
      end
      StOp: begin
        opa_nxt = rdata;
        cnt_nxt = cnt_r - pops_r;
        if (!bvalid_r) opb_nxt = pee_pkg::EmptyVal;
        if (!avalid_r) opa_nxt = pee_pkg::EmptyVal;
        state_nxt = StIdle;
        if (sym_r == pee_pkg::SymMul || sym_r == pee_pkg::SymDiv
            || sym_r == pee_pkg::SymPow) begin
          bvalid_nxt = 1'b1;
          state_nxt  = StAlu;
        end
      end
      StAlu: begin
        // First cycle here starts the unit; bvalid marks that cycle.
        if (!bvalid_r) begin
          addr = AW'(cnt_r);
          if (alu_done) begin
            state_nxt = StIdle;
            push_en   = 1'b1;
            if (sym_r == pee_pkg::SymPow) begin
              if (opb_r == '0) pow_res = W'(1);
              else if (opa_r == '0) pow_res = '0;
              else if (opb_r[W-1]) pow_res = W'(1);
              else pow_res = alu_res;
              push_val = pow_res;
            end else if (sym_r == pee_pkg::SymDiv) begin
              push_en  = (opb_r != '0);
              push_val = alu_res;
            end else begin
              push_val = alu_res;
            end
          end
        end else begin
          alu_ctl.start = 1'b1;
          alu_ctl.op    = (sym_r == pee_pkg::SymMul) ? pee_pkg::OpMul :
                          (sym_r == pee_pkg::SymDiv) ? pee_pkg::OpDiv : pee_pkg::OpPow;
          bvalid_nxt    = 1'b0;
        end
      end
      StNul: begin
        state_nxt = StOut;
        opb_nxt   = (cnt_r == '0) ? pee_pkg::EmptyVal : rdata;
      end
      StOut: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          oval_nxt   = opb_r;
          oovf_nxt   = ovf_r;
          cnt_nxt    = '0;
          state_nxt  = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase

    // + and - finish in StOp; their push happens here too.
    if (state_r == StOp && (sym_r == pee_pkg::SymPlus || sym_r == pee_pkg::SymMinus)) begin
      push_en  = 1'b1;
      push_val = (sym_r == pee_pkg::SymPlus) ? (a_eff + b_eff) : (a_eff - b_eff);
      addr     = AW'(cnt_r - pops_r);
    end

    if (push_en) begin
      if (cnt_nxt >= CW'(STACK_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        we      = 1'b1;
        addr    = AW'(cnt_nxt);
        wdata   = push_val;
        cnt_nxt = cnt_nxt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pops_r   <= pops_nxt;
    sym_r    <= sym_nxt;
    opb_r    <= opb_nxt;
    opa_r    <= opa_nxt;
    bvalid_r <= bvalid_nxt;
    avalid_r <= avalid_nxt;
    oval_r   <= oval_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, oovf_r, oval_r};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag cleared");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(oval_r))
    else $error("result changed while stalled");
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == StOut && slot_free |=> cnt_r == '0) else $error("stack not cleared");
`endif
endmodule

[src/pee_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module pee_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/pee_alu.sv]
// Iterative arithmetic unit: shift-add multiply, restoring divide and
// square-and-multiply power, one bit per cycle. Uses pee_pkg.
module pee_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pee_pkg::alu_ctl_t        ctl,
  input  logic [pee_pkg::DataW-1:0] op_a,
  input  logic [pee_pkg::DataW-1:0] op_b,
  output logic                     done,
  output logic [pee_pkg::DataW-1:0] result
);
  localparam int unsigned W = pee_pkg::DataW;

  logic         busy_r, busy_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [W-1:0] acc_r, acc_nxt;   // product, quotient or power accumulator
  logic [W-1:0] x_r, x_nxt;       // multiplicand, dividend or base
  logic [W-1:0] y_r, y_nxt;       // multiplier, divisor or exponent
  logic [W:0]   rem_r, rem_nxt;
  logic         neg_r, neg_nxt;
  logic         done_r, done_nxt;
  logic [W-1:0] trial_unused_guard;
  logic [W:0]   trial;

  // Power keeps the squared base in x_r. Each step forms acc * base and
  // base * base, both truncated to 32 bits.
  logic [W-1:0] pmul_a, pmul_s;

  always_comb begin
    pmul_a = acc_r * x_r;
    pmul_s = x_r * x_r;
    trial  = {rem_r[W-1:0], x_r[W-1]} - {1'b0, y_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      neg_nxt  = op_a[W-1] ^ op_b[W-1];
      unique case (ctl.op)
        pee_pkg::OpDiv: begin
          acc_nxt = '0;
          x_nxt   = op_a[W-1] ? (W'(0) - op_a) : op_a;
          y_nxt   = op_b[W-1] ? (W'(0) - op_b) : op_b;
        end
        pee_pkg::OpMul: begin
          acc_nxt = '0;
          x_nxt   = op_a;
          y_nxt   = op_b;
        end
        default: begin
          acc_nxt = W'(1);
          x_nxt   = op_a;
          y_nxt   = op_b;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      unique case (op_r)
        pee_pkg::OpDiv: begin
          if (!trial[W]) begin
            rem_nxt = {1'b0, trial[W-1:0]};
          end else begin
            rem_nxt = {rem_r[W-1:0], x_r[W-1]};
          end
          acc_nxt = {acc_r[W-2:0], ~trial[W]};
          x_nxt   = {x_r[W-2:0], 1'b0};
        end
        pee_pkg::OpMul: begin
          if (y_r[0]) begin
            acc_nxt = acc_r + x_r;
          end
          x_nxt = {x_r[W-2:0], 1'b0};
          y_nxt = {1'b0, y_r[W-1:1]};
        end
        default: begin
          if (y_r[0]) begin
            acc_nxt = pmul_a;
          end
          x_nxt = pmul_s;
          y_nxt = {1'b0, y_r[W-1:1]};
        end
      endcase
      if (cnt_r == 6'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign trial_unused_guard = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == pee_pkg::OpDiv && neg_r) ? (W'(0) - acc_r) : acc_r;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("alu done held more than one cycle");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.start) else $error("alu restarted while busy");
`endif
endmodule

[bench/postfix_expression_evaluator_checker.sv]
// Checker for the postfix expression evaluator: watches both stream channels,
// predicts the result of each expression and compares it. Depends on pee_pkg.
`timescale 1ns / 100ps

module postfix_expression_evaluator_checker #(
  parameter int unsigned STACK_DEPTH = pee_pkg::StackDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    logic [31:0] value;
    logic        overflowed;
  } rpn_result_t;

  logic [31:0] operand_mem [STACK_DEPTH];
  int unsigned depth_used;
  logic        sticky_ovf;
  rpn_result_t result_q [$];

  assign pending_count = result_q.size();

  function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex == 0) return 32'd1;
    if (base == 0) return 32'd0;
    if (ex[31]) return 32'd1;
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  task automatic push_operand(logic [31:0] v);
    if (depth_used >= STACK_DEPTH) begin
      sticky_ovf = 1'b1;
    end else begin
      operand_mem[depth_used] = v;
      depth_used++;
    end
  endtask

  task automatic pop_operand(output logic [31:0] v);
    if (depth_used == 0) begin
      v = pee_pkg::EmptyVal;
    end else begin
      depth_used--;
      v = operand_mem[depth_used];
    end
  endtask

  task automatic evaluate_symbol(logic [7:0] sym);
    logic [31:0] op1, op2;
    rpn_result_t r;
    if (sym == pee_pkg::SymNul) begin
      r.value = (depth_used == 0) ? pee_pkg::EmptyVal : operand_mem[depth_used-1];
      r.overflowed = sticky_ovf;
      result_q.push_back(r);
      depth_used = 0;
    end else if (sym >= pee_pkg::SymZero && sym <= pee_pkg::SymNine) begin
      push_operand(32'(sym - pee_pkg::SymZero));
    end else if (sym == pee_pkg::SymPlus || sym == pee_pkg::SymMinus ||
                 sym == pee_pkg::SymMul || sym == pee_pkg::SymDiv ||
                 sym == pee_pkg::SymPow) begin
      pop_operand(op2);
      pop_operand(op1);
      case (sym)
        pee_pkg::SymPlus:  push_operand(op1 + op2);
        pee_pkg::SymMinus: push_operand(op1 - op2);
        pee_pkg::SymMul:   push_operand(op1 * op2);
        pee_pkg::SymDiv:   if (op2 != 0) push_operand(div_toward_zero(op1, op2));
        default:           push_operand(int_pow(op1, op2));
      endcase
    end
  endtask

  always @(posedge clk) begin
    rpn_result_t exp_r;
    if (!rst_n) begin
      depth_used = 0;
      sticky_ovf = 1'b0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) evaluate_symbol(in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d ovf=%0b", $time,
                   $signed(out_tdata[31:0]), out_tdata[32]);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_tdata[31:0] !== exp_r.value) begin
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(exp_r.value), $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[32] !== exp_r.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b", $time,
                     exp_r.overflowed, out_tdata[32]);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[bench/postfix_expression_evaluator_tb.sv]
// Testbench top for the postfix expression evaluator: drives expression
// characters, stalls the result side, and gives the verdict. Depends on
// pee_pkg, the block and postfix_expression_evaluator_checker.
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;
  localparam int IdleLimit = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  bit          calm_phase = 1'b0;   // no idling or stalls near the end
  logic [7:0]  sym_list [$];

  always #1 clk = ~clk;

  postfix_expression_evaluator uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  postfix_expression_evaluator_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending_count
  );

  // The watchdog ends the run once nothing moves on either channel for a
  // long stretch.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side stalls in random bursts.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 3);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Sends one character; the valid stays high across back-to-back
  // transactions unless an idle burst is chosen.
  task automatic send_sym(logic [7:0] sym);
    int n;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0: return pee_pkg::SymPlus;
      1: return pee_pkg::SymMinus;
      2: return pee_pkg::SymMul;
      3: return pee_pkg::SymDiv;
      default: return pee_pkg::SymPow;
    endcase
  endfunction

  // A well-formed expression with random content, sometimes broken by
  // extra operators, stray characters or an overfull stack.
  task automatic queue_expression();
    int depth, len, i;
    depth = 0;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                       : $urandom_range(1, 12);
    for (i = 0; i < len; i++) begin
      if (depth < 2 || ($urandom_range(0, 1) == 0 && len > 40) ||
          $urandom_range(0, 2) == 0) begin
        sym_list.push_back(8'(pee_pkg::SymZero + $urandom_range(0, 9)));
        depth++;
      end else begin
        sym_list.push_back(random_operator());
        depth--;
      end
      if ($urandom_range(0, 19) == 0) sym_list.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 29) == 0) sym_list.push_back(random_operator());
    end
    sym_list.push_back(pee_pkg::SymNul);
  endtask

  initial begin
    string directed;
    int i;
    // Empty result, empty pops, wrap of add, divide by zero, zero powers,
    // negative exponent, and the ignored codes at both ends of the range.
    // A '#' in the directed text stands for the NUL that ends an expression.
    directed = "9#8+*#12-9*/#90/#303^# 05^#";
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < directed.len(); i++) begin
      if (directed[i] == "#")
        send_sym(pee_pkg::SymNul);
      else
        send_sym(directed[i]);
    end
    send_sym(8'hFF); send_sym(8'h80); send_sym(8'h7F); send_sym(pee_pkg::SymNul);
    // Negative base and negative exponent: (0-1) ^ (1-2).
    sym_list = '{pee_pkg::SymZero, 8'h31, pee_pkg::SymMinus, 8'h31, 8'h32,
                 pee_pkg::SymMinus, pee_pkg::SymPow, pee_pkg::SymNul};
    while (sym_list.size() > 0) send_sym(sym_list.pop_front());
    while (i < 1900) begin
      queue_expression();
      i += sym_list.size();
      if (i > 1700) calm_phase = 1'b1;
      while (sym_list.size() > 0) send_sym(sym_list.pop_front());
    end
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
